// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled in reset
`define MAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled in reset
`define MAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/mau_pkg.sv =====
// Package of the modular arithmetic unit: widths, function codes, sequencer types.
// No dependencies.
package mau_pkg;

  localparam int OPERAND_BITS = 31;
  localparam int WIDE_BITS    = 64;
  localparam int CNT_BITS     = 7;
  localparam int COEF_BITS    = OPERAND_BITS + 3;
  localparam logic [OPERAND_BITS-1:0] MOD_RESET = 31'd998244353;

  typedef enum logic [2:0] {
    FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_INV, FN_POW, FN_NEG, FN_RED
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DISPATCH, S_INV_CHK, S_INV_DIV, S_INV_FIX, S_POW, S_DONE
  } state_t;

  // where a finished modular multiply goes
  typedef enum logic [2:0] {
    T_RED_A, T_RED_B, T_RES, T_ACC, T_SQ, T_RED_W
  } mtag_t;

  // where a finished inverse goes
  typedef enum logic [1:0] {
    I_DIV, I_RES, I_POW
  } itag_t;

endpackage

// ===== src/modular_arithmetic_unit.sv =====
// Top level: modular ALU with one shared bit-serial multiply-reduce unit and a
// serial divider for extended Euclid. Depends on mau_pkg.
//
// Operands are first reduced by the multiply-reduce unit; multiply and reduce of the
// wide operand then make one more pass, inverse runs Euclid steps on the divider,
// and power does up to two multiplies per exponent bit.
// One beat at a time: busy stays high until the done strobe; results cannot be stalled.
// Synchronous active-high reset clears the sequencer and loads the modulus reset value.
module modular_arithmetic_unit import mau_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    modulus_we,
  input  logic [OPERAND_BITS-1:0] modulus_wdata,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              func,
  input  logic [OPERAND_BITS-1:0] operand_a,
  input  logic [OPERAND_BITS-1:0] operand_b,
  input  logic signed [WIDE_BITS-1:0] wide_operand,
  output logic                    done,
  output logic [OPERAND_BITS-1:0] result,
  output logic                    a_less_b,
  output logic                    a_equal_b
);

  localparam int OB = OPERAND_BITS;
  localparam int PAD = WIDE_BITS - OPERAND_BITS;

  state_t state, state_next;
  mtag_t  mtag;
  itag_t  itag;
  func_t  fn;

  logic [OB-1:0] modulus;
  logic [OB-1:0] opb, a, b, acc, sq, res;
  logic [WIDE_BITS-1:0] wide, e;
  logic [OB-1:0] mx, mr;
  logic [WIDE_BITS-1:0] my;
  logic [CNT_BITS-1:0] mcnt;
  logic [OB-1:0] ra, rb, rem, dvd;
  logic [4:0] dcnt;
  logic signed [COEF_BITS-1:0] cu, cv, pq;
  logic done_c;

  // shared multiply-reduce step
  logic [OB:0] m32, t0, t1, u0, u1;
  logic [OB-1:0] mul_next;
  always_comb begin
    m32 = {1'b0, modulus};
    t0 = {mr, 1'b0};
    t1 = (t0 >= m32) ? t0 - m32 : t0;
    u0 = t1 + (my[WIDE_BITS-1] ? {1'b0, mx} : '0);
    u1 = (u0 >= m32) ? u0 - m32 : u0;
    mul_next = u1[OB-1:0];
  end

  // divider step and coefficient update
  logic [OB:0] rem2, rem_sub;
  logic        qb;
  logic signed [COEF_BITS-1:0] pq_next, m_s, v1, v2;
  logic [OB-1:0] inv_val;
  always_comb begin
    rem2 = {rem, dvd[OB-1]};
    qb = rem2 >= {1'b0, rb};
    rem_sub = qb ? rem2 - {1'b0, rb} : rem2;
    pq_next = (pq <<< 1) + (qb ? cv : '0);
    m_s = signed'({{(COEF_BITS-OB){1'b0}}, modulus});
    v1 = cu[COEF_BITS-1] ? cu + m_s : cu;
    v2 = (v1 >= m_s) ? v1 - m_s : v1;
    inv_val = v2[OB-1:0];
  end

  // simple combinational results
  logic [OB:0] sum_ab, sum_red, diff_ab;
  logic [WIDE_BITS-1:0] wide_mag;
  always_comb begin
    sum_ab = {1'b0, a} + {1'b0, b};
    sum_red = (sum_ab >= m32) ? sum_ab - m32 : sum_ab;
    diff_ab = (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + m32 - {1'b0, b};
    wide_mag = wide[WIDE_BITS-1] ? (~wide + 1'b1) : wide;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = (modulus < 2) ? S_DONE : S_MUL;
      end
      S_MUL: begin
        if (mcnt == '0) begin
          unique case (mtag)
            T_RED_A, T_ACC: state_next = S_MUL;
            T_RED_B:        state_next = S_DISPATCH;
            T_SQ:           state_next = S_POW;
            T_RES, T_RED_W: state_next = S_DONE;
            default:        state_next = S_DONE;
          endcase
        end
      end
      S_DISPATCH: begin
        unique case (fn)
          FN_MUL, FN_RED: state_next = S_MUL;
          FN_DIV, FN_INV: state_next = S_INV_CHK;
          FN_POW:         state_next = wide[WIDE_BITS-1] ? S_INV_CHK : S_POW;
          default:        state_next = S_DONE;
        endcase
      end
      S_INV_CHK: state_next = (rb == '0) ? S_INV_FIX : S_INV_DIV;
      S_INV_DIV: if (dcnt == '0) state_next = S_INV_CHK;
      S_INV_FIX: begin
        unique case (itag)
          I_DIV:   state_next = S_MUL;
          I_POW:   state_next = S_POW;
          default: state_next = S_DONE;
        endcase
      end
      S_POW:  state_next = (e == '0) ? S_DONE : S_MUL;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy   = (state != S_IDLE);
    done_c = (state == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      modulus <= MOD_RESET;
    end else begin
      state <= state_next;
      done  <= done_c;
      if (modulus_we) modulus <= modulus_wdata;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          fn        <= func_t'(func);
          opb       <= operand_b;
          wide      <= wide_operand;
          a_less_b  <= operand_a < operand_b;
          a_equal_b <= operand_a == operand_b;
          res       <= '0;
          // reduce operand_a as 1 * operand_a
          mx   <= OB'(1);
          my   <= {operand_a, {PAD{1'b0}}};
          mr   <= '0;
          mcnt <= CNT_BITS'(OB);
          mtag <= T_RED_A;
        end
      end
      S_MUL: begin
        if (mcnt != '0) begin
          mr   <= mul_next;
          my   <= my << 1;
          mcnt <= mcnt - 1'b1;
        end else begin
          unique case (mtag)
            T_RED_A: begin
              a    <= mr;
              mx   <= OB'(1);
              my   <= {opb, {PAD{1'b0}}};
              mr   <= '0;
              mcnt <= CNT_BITS'(OB);
              mtag <= T_RED_B;
            end
            T_RED_B: b <= mr;
            T_RES:   res <= mr;
            T_ACC: begin
              acc  <= mr;
              mx   <= sq;
              my   <= {sq, {PAD{1'b0}}};
              mr   <= '0;
              mcnt <= CNT_BITS'(OB);
              mtag <= T_SQ;
            end
            T_SQ: begin
              sq <= mr;
              e  <= e >> 1;
            end
            default: res <= (wide[WIDE_BITS-1] && mr != '0) ? modulus - mr : mr;
          endcase
        end
      end
      S_DISPATCH: begin
        ra <= a;
        rb <= modulus;
        cu <= COEF_BITS'(1);
        cv <= '0;
        acc <= OB'(1);
        sq  <= a;
        e   <= wide_mag;
        itag <= I_RES;
        mr  <= '0;
        unique case (fn)
          FN_ADD: res <= sum_red[OB-1:0];
          FN_SUB: res <= diff_ab[OB-1:0];
          FN_MUL: begin
            mx   <= a;
            my   <= {b, {PAD{1'b0}}};
            mcnt <= CNT_BITS'(OB);
            mtag <= T_RES;
          end
          FN_DIV: begin
            ra   <= b;
            itag <= I_DIV;
          end
          FN_POW: itag <= I_POW;
          FN_NEG: res <= (a != '0) ? modulus - a : '0;
          FN_RED: begin
            mx   <= OB'(1);
            my   <= wide_mag;
            mcnt <= CNT_BITS'(WIDE_BITS);
            mtag <= T_RED_W;
          end
          default: ;
        endcase
      end
      S_INV_CHK: begin
        rem  <= '0;
        dvd  <= ra;
        pq   <= '0;
        dcnt <= 5'(OB);
      end
      S_INV_DIV: begin
        if (dcnt != '0) begin
          rem  <= rem_sub[OB-1:0];
          pq   <= pq_next;
          dvd  <= dvd << 1;
          dcnt <= dcnt - 1'b1;
        end else begin
          // advance one Euclid step
          ra <= rb;
          rb <= rem;
          cu <= cv;
          cv <= cu - pq;
        end
      end
      S_INV_FIX: begin
        unique case (itag)
          I_DIV: begin
            mx   <= a;
            my   <= {inv_val, {PAD{1'b0}}};
            mr   <= '0;
            mcnt <= CNT_BITS'(OB);
            mtag <= T_RES;
          end
          I_POW:   sq <= inv_val;
          default: res <= inv_val;
        endcase
      end
      S_POW: begin
        mr   <= '0;
        mcnt <= CNT_BITS'(OB);
        if (e == '0) begin
          res <= acc;
        end else if (e[0]) begin
          mx   <= acc;
          my   <= {sq, {PAD{1'b0}}};
          mtag <= T_ACC;
        end else begin
          mx   <= sq;
          my   <= {sq, {PAD{1'b0}}};
          mtag <= T_SQ;
        end
      end
      default: ;
    endcase
  end

  assign result = res;

endmodule

// ===== src/mau_checker.sv =====
// Port-level checker for the modular arithmetic unit, bound to the top level.
// Depends on mau_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mau_checker import mau_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `MAU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `MAU_ASSERT_NOW(a_done_idle, done, !busy, "done strobe while still busy")
  `MAU_ASSERT_NEXT(a_done_pulse, done, !done, "done strobe longer than one cycle")
  `MAU_ASSERT_NOW(a_done_after_busy, done, $past(busy), "done strobe without a beat in work")

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);
